FILE: design/arqtx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arqtx_pkg
// Shared types and codes for the selective-repeat ARQ transmitter.
// ----------------------------------------------------------------------------
package arqtx_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BURST = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REG_OWN_ID    = 2'd0;
    localparam logic [1:0] REG_PARTNER   = 2'd1;
    localparam logic [1:0] REG_PKT_BYTES = 2'd2;
    localparam logic [1:0] REG_GUARD     = 2'd3;

    localparam logic [7:0] END_FLAG = 8'h01;

    // transmit sequencer phases
    typedef enum logic [5:0] {
        PH_WAIT  = 6'b000001,
        PH_BUF   = 6'b000010,
        PH_ID    = 6'b000100,
        PH_NUM   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_GUARD = 6'b100000
    } phase_t;

    // one result item
    typedef struct packed {
        logic       acked;
        logic       session_started;
        logic       loading;
        logic       channel_fresh;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } result_t;

endpackage

FILE: design/arqtx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arqtx_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arqtx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: design/arq_packet_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_packet_transmitter
// Selective-repeat ARQ sender: packet store, feedback handling, tx sequencer.
// ----------------------------------------------------------------------------
// Use: items arrive on the s_ channel; tuser carries the kind (0 load byte,
// 1 feedback burst, 2 output tick) and tdata the load byte then the six
// feedback bytes. Every accepted item yields exactly one result on m_:
// tx_byte for a tick, plus status flags. Configuration is written on the
// cfg_ channel while the block is idle.
// Pipeline: a request enters a one-stage read pipeline (memory read of the
// payload store and the slot flag table) and its result is then registered
// in the output register, from which it is offered on m_.
// Throughput: one item per cycle unless m_ stalls or a clearing pass runs;
// the slot flag table and payload RAM are read as a request enters stage 1,
// and a one-entry forward covers back-to-back accesses to the same slot.
// Reset: all control state clears at once; the slot flag table is cleared by
// a pass over all PACKET_SLOTS slots after reset and after each new session,
// during which no request is accepted. Payload is undefined until loaded.
// Stall: when a result waits and m_tready is low the output holds, the
// pipeline stops and the waiting request re-reads its memory words.
// ----------------------------------------------------------------------------
module arq_packet_transmitter #(
    parameter int PACKET_SLOTS     = 255,
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte, fb_byte0 .. fb_byte5
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte
    output logic [4:0]  m_tuser,   // tx_valid, channel_fresh, loading,
                                   // session_started, acked
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import arqtx_pkg::*;

    localparam int SW = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;
    localparam int BW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int AW = $clog2(PACKET_SLOTS * MAX_PACKET_BYTES);

    // configuration
    logic [7:0] own_id_reg, partner_id_reg, guard_reg;
    logic [6:0] pbytes_reg;

    // control state
    phase_t     phase_reg;
    logic       check_reg, load_mode_reg, load_done_reg, chan_reg;
    logic [7:0] load_slot_reg, load_off_reg, sess_pk_reg, send_slot_reg;
    logic [7:0] pcount_reg, exp_sess_reg;
    logic       clr_reg;
    logic [SW-1:0] clr_addr_reg;

    // stage 1: accepted request waiting for memory reads
    logic        v1_reg;
    logic [1:0]  kind1_reg;
    logic [55:0] data1_reg;

    // output register
    logic    out_v_reg;
    result_t out_reg;

    logic adv;
    assign adv = !out_v_reg || m_tready;
    assign s_tready = adv && !clr_reg;
    assign cfg_ready = 1'b1;

    // effective packet bytes and guard
    logic [7:0] eff_pb, eff_gl;
    always_comb begin
        eff_pb = {1'b0, pbytes_reg};
        if (eff_pb < 8'd1) eff_pb = 8'd1;
        if (int'(eff_pb) > MAX_PACKET_BYTES) eff_pb = 8'(MAX_PACKET_BYTES);
        eff_gl = (guard_reg == 8'd0) ? 8'd1 : guard_reg;
    end

    // ---------------- flag table: {loaded, sent, confirmed} per slot
    logic          fl_we;
    logic [SW-1:0] fl_waddr, fl_raddr;
    logic [2:0]    fl_wdata, fl_rdata;
    arqtx_ram #(.WIDTH(3), .DEPTH(PACKET_SLOTS)) u_flags (
        .aclk(aclk), .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
        .rd_addr(fl_raddr), .rd_data(fl_rdata)
    );

    // ---------------- payload store
    logic          pl_we;
    logic [AW-1:0] pl_waddr, pl_raddr;
    logic [7:0]    pl_wdata, pl_rdata;
    arqtx_ram #(.WIDTH(8), .DEPTH(PACKET_SLOTS * MAX_PACKET_BYTES)) u_payload (
        .aclk(aclk), .wr_en(pl_we), .wr_addr(pl_waddr), .wr_data(pl_wdata),
        .rd_addr(pl_raddr), .rd_data(pl_rdata)
    );

    // address prediction for the request entering stage 1; while stalled,
    // re-read for the request held in stage 1
    logic [1:0]  in_kind;
    logic [55:0] in_data;
    logic [7:0]  nvote, s_cur, s_rd;
    logic [7:0]  in_fb [6];
    logic        take;
    assign take = s_tvalid && s_tready;
    assign in_kind = adv ? s_tuser : kind1_reg;
    assign in_data = adv ? s_tdata : data1_reg;
    always_comb begin
        for (int k = 0; k < 6; k++) in_fb[k] = in_data[8*(k+1) +: 8];
    end

    // slot the tick in stage 1 will use once stage 1 state settles;
    // state seen here is already the state after the stage 1 request
    logic [7:0] slot_after;   // computed below from next-state
    logic [7:0] pc_after;
    always_comb begin
        if (in_fb[3] == in_fb[4]) nvote = in_fb[3];
        else if (in_fb[4] == in_fb[5]) nvote = in_fb[4];
        else nvote = in_fb[5];
        s_rd = (in_kind == KIND_BURST) ? nvote - 8'd1 : slot_after;
        s_cur = (s_rd < 8'(PACKET_SLOTS)) ? s_rd : 8'd0;
        fl_raddr = SW'(s_cur);
        pl_raddr = AW'(s_cur * 16'(MAX_PACKET_BYTES) + 16'(pc_after[BW-1:0]));
    end

    // forwarding of a flag write landing in the read cycle
    logic          fwd_v_reg;
    logic [SW-1:0] fwd_a_reg, rd_a_reg;
    logic [2:0]    fwd_d_reg, flags;
    assign flags = (fwd_v_reg && fwd_a_reg == rd_a_reg) ? fwd_d_reg : fl_rdata;

    // ---------------- stage 2: execute with memory data
    phase_t     phase_next;
    logic       check_next, lm_next, ld_next, chan_next, clr_start;
    logic [7:0] ls_next, lo_next, sp_next, ss_next, pc_next, es_next;
    result_t    res;
    logic [7:0] fb [6];
    logic [7:0] n1, s1, cnt;
    logic       voted;

    always_comb begin
        phase_next = phase_reg; check_next = check_reg; lm_next = load_mode_reg;
        ld_next = load_done_reg; chan_next = chan_reg; ls_next = load_slot_reg;
        lo_next = load_off_reg; sp_next = sess_pk_reg; ss_next = send_slot_reg;
        pc_next = pcount_reg; es_next = exp_sess_reg; clr_start = 1'b0;
        res = '0;
        fl_we = 1'b0; fl_waddr = clr_addr_reg; fl_wdata = 3'b000;
        pl_we = 1'b0; pl_wdata = data1_reg[7:0];
        pl_waddr = AW'(load_slot_reg[SW-1:0] * 16'(MAX_PACKET_BYTES)
                       + 16'(load_off_reg - 8'd1));
        for (int k = 0; k < 6; k++) fb[k] = data1_reg[8*(k+1) +: 8];
        s1 = (send_slot_reg < 8'(PACKET_SLOTS)) ? send_slot_reg : 8'd0;
        n1 = 8'd0; voted = 1'b1; cnt = 8'd0;
        if (clr_reg) begin
            fl_we = 1'b1;
        end
        if (v1_reg && adv) begin
            unique case (kind1_reg)
                KIND_LOAD: begin
                    if (load_mode_reg) begin
                        if (load_off_reg == 8'd0) begin
                            if (data1_reg[7:0] == END_FLAG) begin
                                if (sess_pk_reg > 8'd0) sp_next = sess_pk_reg - 8'd1;
                                ls_next = 8'd0; lm_next = 1'b0; ld_next = 1'b1;
                            end else begin
                                lo_next = 8'd1;
                            end
                        end else begin
                            pl_we = 1'b1;
                            lo_next = load_off_reg + 8'd1;
                            if (lo_next >= eff_pb + 8'd1) begin
                                lo_next = 8'd0;
                                if (sess_pk_reg < 8'd255) sp_next = sess_pk_reg + 8'd1;
                                fl_we = 1'b1;
                                fl_waddr = SW'(load_slot_reg);
                                fl_wdata = 3'b100;
                                ls_next = load_slot_reg + 8'd1;
                                if (ls_next >= 8'(PACKET_SLOTS)) begin
                                    ls_next = 8'd0; lm_next = 1'b0; ld_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                KIND_BURST: begin
                    if (!load_mode_reg && !check_reg) begin
                        if (fb[0] == partner_id_reg && fb[1] == partner_id_reg
                            && fb[2] == partner_id_reg) begin
                            chan_next = 1'b1;
                            if (fb[3] == fb[4]) n1 = fb[3];
                            else if (fb[4] == fb[5]) n1 = fb[4];
                            else if (fb[5] == fb[3]) n1 = fb[5];
                            else voted = 1'b0;
                            if (voted) begin
                                if (n1 == 8'd0) begin
                                    check_next = 1'b1;
                                end else if (n1 - 8'd1 < 8'(PACKET_SLOTS)
                                             && flags[1]) begin
                                    fl_we = 1'b1; fl_waddr = SW'(n1 - 8'd1);
                                    fl_wdata = flags | 3'b001;
                                    res.acked = 1'b1;
                                end
                            end
                        end
                    end else if (!load_mode_reg) begin
                        for (int k = 0; k < 6; k++)
                            cnt = cnt + 8'(fb[k] == exp_sess_reg);
                        if (cnt > 8'd4) begin
                            chan_next = 1'b1;
                            es_next = (exp_sess_reg == 8'hFF) ? 8'd1 : exp_sess_reg + 8'd1;
                            clr_start = 1'b1;
                            sp_next = 8'd0; ss_next = 8'd0; pc_next = 8'd0;
                            phase_next = PH_WAIT; ls_next = 8'd0; lo_next = 8'd0;
                            lm_next = 1'b1; ld_next = 1'b0;
                            res.session_started = 1'b1;
                        end
                        check_next = 1'b0;
                    end
                end
                KIND_TICK: begin
                    res.tx_valid = 1'b1;
                    res.channel_fresh = chan_reg;
                    chan_next = 1'b0;
                    unique case (phase_reg)
                        PH_WAIT: if (load_done_reg) phase_next = PH_BUF;
                        PH_BUF: begin
                            if (!flags[0]) phase_next = PH_ID;
                            else begin
                                ss_next = send_slot_reg + 8'd1;
                                if (ss_next >= sess_pk_reg || ss_next >= 8'(PACKET_SLOTS))
                                    ss_next = 8'd0;
                            end
                        end
                        PH_ID: begin
                            res.tx_byte = own_id_reg;
                            pc_next = pcount_reg + 8'd1;
                            if (pc_next >= 8'd3) begin
                                pc_next = 8'd0; phase_next = PH_NUM;
                            end
                        end
                        PH_NUM: begin
                            res.tx_byte = flags[2] ? s1 + 8'd1 : 8'd0;
                            fl_we = 1'b1; fl_waddr = SW'(s1);
                            fl_wdata = {flags[2], flags[2], flags[0]};
                            pc_next = pcount_reg + 8'd1;
                            if (pc_next >= 8'd3) begin
                                pc_next = 8'd0; phase_next = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            res.tx_byte = pl_rdata;
                            pc_next = pcount_reg + 8'd1;
                            if (pc_next >= eff_pb) begin
                                pc_next = 8'd0; phase_next = PH_GUARD;
                            end
                        end
                        PH_GUARD: begin
                            pc_next = pcount_reg + 8'd1;
                            if (pc_next >= eff_gl) begin
                                pc_next = 8'd0; phase_next = PH_BUF;
                                ss_next = send_slot_reg + 8'd1;
                                if (ss_next >= sess_pk_reg || ss_next >= 8'(PACKET_SLOTS))
                                    ss_next = 8'd0;
                            end
                        end
                        default: phase_next = PH_WAIT;
                    endcase
                end
                default: ;
            endcase
            res.loading = lm_next;
        end
        slot_after = (v1_reg && adv) ? ss_next : send_slot_reg;
        pc_after = (v1_reg && adv) ? pc_next : pcount_reg;
    end

    // ---------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= 8'd1; partner_id_reg <= 8'd2;
            pbytes_reg <= 7'd64; guard_reg <= 8'd16;
            phase_reg <= PH_WAIT; check_reg <= 1'b0; load_mode_reg <= 1'b0;
            load_done_reg <= 1'b0; chan_reg <= 1'b0; load_slot_reg <= '0;
            load_off_reg <= '0; sess_pk_reg <= '0; send_slot_reg <= '0;
            pcount_reg <= '0; exp_sess_reg <= 8'd1;
            clr_reg <= 1'b1; clr_addr_reg <= '0;
            v1_reg <= 1'b0; out_v_reg <= 1'b0; fwd_v_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_OWN_ID:    own_id_reg <= cfg_data;
                    REG_PARTNER:   partner_id_reg <= cfg_data;
                    REG_PKT_BYTES: pbytes_reg <= cfg_data[6:0];
                    REG_GUARD:     guard_reg <= cfg_data;
                    default: ;
                endcase
            end
            phase_reg <= phase_next; check_reg <= check_next;
            load_mode_reg <= lm_next; load_done_reg <= ld_next;
            chan_reg <= chan_next; load_slot_reg <= ls_next;
            load_off_reg <= lo_next; sess_pk_reg <= sp_next;
            send_slot_reg <= ss_next; pcount_reg <= pc_next;
            exp_sess_reg <= es_next;
            // clearing pass over the flag table
            if (clr_start) begin
                clr_reg <= 1'b1; clr_addr_reg <= '0;
            end else if (clr_reg) begin
                if (clr_addr_reg == SW'(PACKET_SLOTS - 1)) clr_reg <= 1'b0;
                else clr_addr_reg <= clr_addr_reg + SW'(1);
            end
            fwd_v_reg <= fl_we;
            if (adv) begin
                v1_reg <= take;
                out_v_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fwd_a_reg <= fl_waddr; fwd_d_reg <= fl_wdata; rd_a_reg <= fl_raddr;
        if (adv) begin
            kind1_reg <= in_kind; data1_reg <= in_data;
            if (v1_reg) out_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.tx_byte;
    assign m_tuser  = {out_reg.acked, out_reg.session_started, out_reg.loading,
                       out_reg.channel_fresh, out_reg.tx_valid};
endmodule

FILE: design/arqtx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arqtx_checker
// Port-level checks for the ARQ transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module arqtx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [4:0] m_tuser
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a non-tick result carries no byte
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("byte on non-tick result");

    // ack and session start come only from bursts, never with a tick
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[3] && !m_tuser[4])
        else $error("burst flags on tick");

    // a session start leaves the block loading
    a_sess: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2])
        else $error("session start without loading");
endmodule

bind arq_packet_transmitter arqtx_checker u_arqtx_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat ARQ transmitter.
// ----------------------------------------------------------------------------
// Drives load bytes, feedback bursts and output ticks on the s_ channel and
// keeps a cycle-free model of the sender (packet store, slot marks, session
// check, transmit sequencer). Each accepted request queues one expected
// result, which is compared field by field with the m_ channel in order.
// Directed checks come first, then session cycles with random content under
// three idling patterns, with register changes between cycles.
// ----------------------------------------------------------------------------
module tb;
    import arqtx_pkg::*;

    localparam int SLOTS   = 255;
    localparam int MAXB    = 64;
    localparam int LIMIT   = 5000;
    localparam int N_ITEMS = 1400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [4:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    arq_packet_transmitter uut (.*);

    always #10 aclk = ~aclk;

    // sender state model
    logic [7:0] own_id_r, partner_r, guard_r;
    logic [6:0] pkt_bytes_r;
    phase_t     tx_phase;
    logic       chk_session, load_on, load_finished, chan_pending;
    int         fill_slot, fill_off, pkt_count, tx_slot, phase_cnt;
    logic [7:0] next_session;
    logic       loaded_f [SLOTS];
    logic       sent_f   [SLOTS];
    logic       conf_f   [SLOTS];
    logic [7:0] payload  [SLOTS*MAXB];
    logic       written  [SLOTS*MAXB];

    result_t    expected_q [$];
    int         items_sent = 0;
    int         s_idle = 0, r_idle = 0;
    bit         failed = 1'b0;
    int         quiet = 0;

    function automatic int eff_bytes();
        if (pkt_bytes_r == 0) return 1;
        if (pkt_bytes_r > MAXB) return MAXB;
        return int'(pkt_bytes_r);
    endfunction

    function automatic void advance_slot();
        tx_slot++;
        if (tx_slot >= pkt_count || tx_slot >= SLOTS) tx_slot = 0;
    endfunction

    function automatic void open_session();
        for (int i = 0; i < SLOTS; i++) begin
            loaded_f[i] = 0; sent_f[i] = 0; conf_f[i] = 0;
        end
        pkt_count = 0; tx_slot = 0; phase_cnt = 0; tx_phase = PH_WAIT;
        fill_slot = 0; fill_off = 0; load_on = 1; load_finished = 0;
    endfunction

    function automatic void model_reset();
        own_id_r = 8'd1; partner_r = 8'd2; pkt_bytes_r = 7'd64; guard_r = 8'd16;
        open_session();
        load_on = 0; chk_session = 0; chan_pending = 0; next_session = 8'd1;
        for (int i = 0; i < SLOTS*MAXB; i++) begin
            payload[i] = '0; written[i] = 0;
        end
    endfunction

    // a tick now would read payload that was never loaded
    function automatic bit tick_unsafe();
        return tx_phase == PH_DATA && phase_cnt < MAXB &&
               !written[tx_slot*MAXB + phase_cnt];
    endfunction

    function automatic void store_byte(logic [7:0] d);
        if (fill_off == 0) begin
            if (d == END_FLAG) begin
                if (pkt_count > 0) pkt_count--;
                fill_slot = 0; load_on = 0; load_finished = 1;
            end else begin
                fill_off = 1;
            end
            return;
        end
        payload[fill_slot*MAXB + fill_off - 1] = d;
        written[fill_slot*MAXB + fill_off - 1] = 1;
        fill_off++;
        if (fill_off >= eff_bytes() + 1) begin
            fill_off = 0;
            if (pkt_count < 255) pkt_count++;
            loaded_f[fill_slot] = 1;
            fill_slot++;
            if (fill_slot >= SLOTS) begin
                fill_slot = 0; load_on = 0; load_finished = 1;
            end
        end
    endfunction

    function automatic void take_feedback(logic [47:0] fb, ref result_t r);
        logic [7:0] b [6];
        logic [7:0] n;
        int cnt = 0;
        bit voted = 1;
        for (int k = 0; k < 6; k++) b[k] = fb[8*k +: 8];
        if (!chk_session) begin
            for (int k = 0; k < 3; k++) if (b[k] == partner_r) cnt++;
            if (cnt == 3) begin
                chan_pending = 1;
                if (b[3] == b[4]) n = b[3];
                else if (b[4] == b[5]) n = b[4];
                else if (b[5] == b[3]) n = b[5];
                else voted = 0;
                if (voted) begin
                    if (n == 0) chk_session = 1;
                    else if (sent_f[n-1]) begin
                        conf_f[n-1] = 1;
                        r.acked = 1;
                    end
                end
            end
            return;
        end
        for (int k = 0; k < 6; k++) if (b[k] == next_session) cnt++;
        if (cnt > 4) begin
            chan_pending = 1;
            next_session = (next_session == 8'hFF) ? 8'd1 : next_session + 8'd1;
            open_session();
            r.session_started = 1;
        end
        chk_session = 0;
    endfunction

    function automatic logic [7:0] tick_byte();
        logic [7:0] o = '0;
        int gl = (guard_r == 0) ? 1 : int'(guard_r);
        int s = tx_slot;
        case (tx_phase)
            PH_WAIT: if (load_finished) tx_phase = PH_BUF;
            PH_BUF: begin
                if (!conf_f[s]) tx_phase = PH_ID;
                else advance_slot();
            end
            PH_ID: begin
                o = own_id_r;
                if (++phase_cnt >= 3) begin phase_cnt = 0; tx_phase = PH_NUM; end
            end
            PH_NUM: begin
                o = loaded_f[s] ? 8'(s + 1) : 8'd0;
                sent_f[s] = loaded_f[s];
                if (++phase_cnt >= 3) begin phase_cnt = 0; tx_phase = PH_DATA; end
            end
            PH_DATA: begin
                if (phase_cnt < MAXB) o = payload[s*MAXB + phase_cnt];
                if (++phase_cnt >= eff_bytes()) begin
                    phase_cnt = 0; tx_phase = PH_GUARD;
                end
            end
            default: begin
                if (++phase_cnt >= gl) begin
                    phase_cnt = 0; tx_phase = PH_BUF; advance_slot();
                end
            end
        endcase
        return o;
    endfunction

    function automatic result_t predict_result(logic [1:0] kind, logic [55:0] d);
        result_t r = '0;
        if (kind == KIND_LOAD) begin
            if (load_on) store_byte(d[7:0]);
        end else if (kind == KIND_BURST) begin
            if (!load_on) take_feedback(d[55:8], r);
        end else if (kind == KIND_TICK) begin
            r.channel_fresh = chan_pending;
            chan_pending = 0;
            r.tx_byte = tick_byte();
            r.tx_valid = 1;
        end
        r.loading = load_on;
        return r;
    endfunction

    // send one request, with random hold-off before it
    task automatic send_item(logic [1:0] kind, logic [55:0] d);
        while ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_result(kind, d));
        items_sent++;
    endtask

    task automatic send_burst(logic [47:0] fb);
        send_item(KIND_BURST, {fb, 8'($urandom)});
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 56'({$urandom, $urandom}));
    endtask

    task automatic send_load(logic [7:0] b);
        send_item(KIND_LOAD, {48'($urandom), b});
    endtask

    // drain all outstanding results, then allow the pipeline to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OWN_ID:    own_id_r = v;
            REG_PARTNER:   partner_r = v;
            REG_PKT_BYTES: pkt_bytes_r = v[6:0];
            default:       guard_r = v;
        endcase
        @(posedge aclk);
    endtask

    // voted number n, sometimes with one copy corrupted at random
    function automatic logic [23:0] voted_num(logic [7:0] n);
        logic [23:0] v = {3{n}};
        if ($urandom_range(2) == 0) v[8*$urandom_range(2) +: 8] = 8'($urandom);
        return v;
    endfunction

    task automatic start_session();
        logic [47:0] s;
        for (int t = 0; t < 4 && !load_on; t++) begin
            send_burst({voted_num(8'd0), {3{partner_r}}});
            s = {6{next_session}};
            if ($urandom_range(1)) s[8*$urandom_range(5) +: 8] = 8'($urandom);
            send_burst(s);
        end
    endtask

    // hold reset, bring up the model
    task automatic test_reset();
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_registers();
        write_reg(REG_OWN_ID, 8'hFF);
        write_reg(REG_PARTNER, 8'h01);
        write_reg(REG_PKT_BYTES, 8'h00);
        write_reg(REG_GUARD, 8'h00);
    endtask

    // idle behaviour, session check, one short packet and its confirmation
    task automatic test_directed();
        send_tick();
        send_load(8'h55);
        send_item(KIND_NONE, {56{1'b1}});
        send_burst({24'h000000, 8'h01, 8'h01, 8'h07});
        send_burst({8'h03, 8'h02, 8'h01, 24'h010101});
        send_burst({8'h00, 8'h09, 8'h00, 24'h010101});
        send_burst({24'h010101, 24'h0000FF});
        send_burst({8'h07, 16'h0000, 24'h010101});
        send_burst({24'h010101, 24'h01FF01});
        send_burst({24'h000000, 24'h010101});
        send_load(8'hFF);
        send_load(8'h00);
        send_load(8'h00);
        send_load(8'hFF);
        send_load(END_FLAG);
        repeat (10) send_tick();
        send_burst({8'h01, 16'h0101, 24'h010101});
        send_burst({24'h090909, 24'h010101});
        send_burst({24'hFFFFFF, 24'h010101});
        wait_idle();
    endtask

    // fill every slot, so loading stops on a full store
    task automatic test_full_store();
        write_reg(REG_PKT_BYTES, 8'd1);
        start_session();
        while (load_on) send_load(8'($urandom) | 8'h02);
        repeat (12) send_tick();
        wait_idle();
    endtask

    task automatic random_config();
        logic [7:0] v;
        wait_idle();
        case ($urandom_range(3))
            0: v = 8'hFF; 1: v = 8'h01; default: v = 8'($urandom_range(1, 255));
        endcase
        write_reg(REG_OWN_ID, v);
        write_reg(REG_PARTNER, $urandom_range(3) == 0 ? 8'hFF : 8'($urandom_range(1, 255)));
        case ($urandom_range(7))
            0: v = 8'd0; 1: v = 8'd127; 2: v = 8'd64; 3: v = 8'd65;
            default: v = 8'($urandom_range(1, 6));
        endcase
        write_reg(REG_PKT_BYTES, v);
        case ($urandom_range(9))
            0: v = 8'd0; 1: v = 8'd255; 2: v = 8'd1;
            default: v = 8'($urandom_range(1, 8));
        endcase
        write_reg(REG_GUARD, v);
    endtask

    // one session: open, load a few packets, transmit with feedback mixed in
    task automatic session_cycle();
        int npk, nt;
        logic [7:0] f;
        if ($urandom_range(2) == 0) random_config();
        start_session();
        npk = $urandom_range(0, 4);
        for (int p = 0; p < npk && load_on; p++) begin
            f = 8'($urandom);
            if (f == END_FLAG) f = 8'h80;
            send_load(f);
            for (int i = 0; i < eff_bytes(); i++) begin
                if ($urandom_range(19) == 0) send_burst(48'({$urandom, $urandom}));
                if ($urandom_range(29) == 0) send_tick();
                send_load(8'($urandom));
            end
        end
        if (load_on) send_load(END_FLAG);
        nt = $urandom_range(20, 150);
        for (int i = 0; i < nt; i++) begin
            case ($urandom_range(9))
                7, 8: begin
                    if ($urandom_range(3) != 0)
                        send_burst({voted_num(8'($urandom_range(1, npk + 1))),
                                    {3{partner_r}}});
                    else
                        send_burst(48'({$urandom, $urandom}));
                end
                9: begin
                    if ($urandom_range(1))
                        send_item(KIND_NONE, 56'({$urandom, $urandom}));
                    else send_load(8'($urandom));
                end
                default: begin
                    if (tick_unsafe()) break;
                    send_tick();
                end
            endcase
        end
    endtask

    task automatic test_random(int sender_idle, int receiver_idle, int n);
        int stop;
        s_idle = sender_idle;
        r_idle = receiver_idle;
        stop = items_sent + n;
        while (items_sent < stop) session_cycle();
        wait_idle();
    endtask

    // receiver back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= r_idle);

    // compare each result with the oldest expectation; watchdog on progress
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
                failed = 1'b1;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tdata !== exp_r.tx_byte) begin
                    $error("tx_byte exp %h got %h", exp_r.tx_byte, m_tdata);
                    failed = 1'b1;
                end
                if (m_tuser[0] !== exp_r.tx_valid) begin
                    $error("tx_valid exp %b got %b", exp_r.tx_valid, m_tuser[0]);
                    failed = 1'b1;
                end
                if (m_tuser[1] !== exp_r.channel_fresh) begin
                    $error("channel_fresh exp %b got %b", exp_r.channel_fresh, m_tuser[1]);
                    failed = 1'b1;
                end
                if (m_tuser[2] !== exp_r.loading) begin
                    $error("loading exp %b got %b", exp_r.loading, m_tuser[2]);
                    failed = 1'b1;
                end
                if (m_tuser[3] !== exp_r.session_started) begin
                    $error("session_started exp %b got %b",
                           exp_r.session_started, m_tuser[3]);
                    failed = 1'b1;
                end
                if (m_tuser[4] !== exp_r.acked) begin
                    $error("acked exp %b got %b", exp_r.acked, m_tuser[4]);
                    failed = 1'b1;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        test_reset();
        test_registers();
        test_directed();
        test_full_store();
        // share what is left of the item budget across the idling patterns
        test_random(14, 75, (N_ITEMS - items_sent) / 3);
        test_random(75, 14, (N_ITEMS - items_sent) / 2);
        test_random(0, 0, N_ITEMS - items_sent);
        if (!failed) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
